// File: rtl/cprp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprp_pkg
// Types, constants and helper functions shared by the price row parser.
// ----------------------------------------------------------------------------
package cprp_pkg;

    localparam int FRAC_DIGITS = 6;
    localparam int FRAC_EFF    = (FRAC_DIGITS > 9) ? 9 : FRAC_DIGITS;

    localparam int TOK_DEPTH = 2;
    localparam int TOK_AW    = 1;
    localparam int RES_DEPTH = 2;
    localparam int RES_AW    = 1;

    localparam logic [63:0] MAG_CAP = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] FIELD_COUNT_MIN = 3'd6;
    localparam logic [2:0] FIELD_FIRST     = 3'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in;

    typedef struct packed {
        logic signed [63:0] open_value;
        logic signed [63:0] high_value;
        logic signed [63:0] low_value;
        logic signed [63:0] close_value;
        logic signed [63:0] volume_value;
    } t_res;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_COMMA,
        CLS_EOL,
        CLS_BLANK,
        CLS_MINUS,
        CLS_PLUS,
        CLS_POINT,
        CLS_OTHER
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [3:0] digit;
    } t_tok;

    typedef enum logic [2:0] {
        PH_BLANK,
        PH_MINUS,
        PH_INT,
        PH_FRAC,
        PH_STOP
    } t_phase;

    function automatic logic [29:0] pow_ten(input logic [3:0] e);
        logic [29:0] p;
        case (e)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd0;
        endcase
        return p;
    endfunction

    function automatic logic [33:0] digit_scale(input logic [3:0] d, input logic [3:0] e);
        return 34'(d) * 34'(pow_ten(e));
    endfunction

endpackage

// File: rtl/cprp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprp_front
// Header skip and byte classification; adds a line end after a file's last
// byte when that byte does not end the line itself.
// ----------------------------------------------------------------------------
module cprp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  cprp_pkg::t_in i_in,
    output logic          o_tok_push,
    output cprp_pkg::t_tok o_tok,
    input  logic          i_tok_full
);
    import cprp_pkg::*;

    logic r_hdr;
    logic n_hdr;
    logic r_pend;
    logic n_pend;
    logic accept;
    t_tok byte_tok;

    always_comb begin
        byte_tok.digit = i_in.data_byte[3:0];
        if (i_in.data_byte inside {[CH_ZERO:CH_NINE]}) begin
            byte_tok.cls = CLS_DIGIT;
        end else if (i_in.data_byte == CH_COMMA) begin
            byte_tok.cls = CLS_COMMA;
        end else if (i_in.data_byte == CH_LF || i_in.data_byte == CH_CR) begin
            byte_tok.cls = CLS_EOL;
        end else if (i_in.data_byte == CH_SPACE || i_in.data_byte == CH_TAB) begin
            byte_tok.cls = CLS_BLANK;
        end else if (i_in.data_byte == CH_MINUS) begin
            byte_tok.cls = CLS_MINUS;
        end else if (i_in.data_byte == CH_PLUS) begin
            byte_tok.cls = CLS_PLUS;
        end else if (i_in.data_byte == CH_POINT) begin
            byte_tok.cls = CLS_POINT;
        end else begin
            byte_tok.cls = CLS_OTHER;
        end
    end

    assign full   = r_pend || i_tok_full;
    assign accept = push && !full;

    always_comb begin
        n_hdr      = r_hdr;
        n_pend     = r_pend;
        o_tok_push = 1'b0;
        o_tok      = byte_tok;
        if (r_pend) begin
            o_tok.cls = CLS_EOL;
            if (!i_tok_full) begin
                o_tok_push = 1'b1;
                n_pend     = 1'b0;
                n_hdr      = 1'b1;
            end
        end else if (accept) begin
            if (r_hdr) begin
                if (i_in.data_byte == CH_LF && !i_in.end_of_file) begin
                    n_hdr = 1'b0;
                end
            end else begin
                o_tok_push = 1'b1;
                if (i_in.end_of_file) begin
                    if (byte_tok.cls == CLS_EOL) begin
                        n_hdr = 1'b1;
                    end else begin
                        n_pend = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr  <= 1'b1;
            r_pend <= 1'b0;
        end else begin
            r_hdr  <= n_hdr;
            r_pend <= n_pend;
        end
    end

endmodule

// File: rtl/cprp_tok_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprp_tok_fifo
// Short token queue between the classifier and the number parser.
// ----------------------------------------------------------------------------
module cprp_tok_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cprp_pkg::t_tok i_tok,
    output logic           o_full,
    output logic           o_valid,
    output cprp_pkg::t_tok o_tok,
    input  logic           i_pop
);
    import cprp_pkg::*;

    t_tok              r_mem [TOK_DEPTH];
    logic [TOK_AW-1:0] r_wr;
    logic [TOK_AW-1:0] r_rd;
    logic [TOK_AW:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == (TOK_AW+1)'(TOK_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/cprp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprp_back
// Field counting and saturating decimal to fixed point conversion; builds one
// row result at each line end that closes a row with enough fields.
// ----------------------------------------------------------------------------
module cprp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tok_valid,
    input  cprp_pkg::t_tok i_tok,
    output logic           o_tok_pop,
    output logic           o_res_push,
    output cprp_pkg::t_res o_res,
    input  logic           i_res_full
);
    import cprp_pkg::*;

    logic [2:0]  r_cc;
    logic [2:0]  n_cc;
    logic        r_has;
    logic        n_has;
    t_phase      r_phase;
    t_phase      n_phase;
    logic        r_neg;
    logic        n_neg;
    logic [63:0] r_mant;
    logic [63:0] n_mant;
    logic [3:0]  r_fc;
    logic [3:0]  n_fc;
    logic [63:0] r_fld [4];
    logic [63:0] n_fld [4];

    logic [63:0] num_val;
    logic [67:0] int_sum;
    logic [63:0] int_mant;
    logic [64:0] frac_sum;
    logic [63:0] frac_mant;
    logic [3:0]  frac_exp;
    logic        frac_room;
    logic        take;
    logic        int_rule;

    assign take      = i_tok_valid && !i_res_full;
    assign o_tok_pop = take;

    assign num_val = r_neg ? (64'd0 - r_mant) : (r_mant[63] ? MAG_MAX : r_mant);

    assign int_sum  = {1'b0, r_mant, 3'b000} + {3'b000, r_mant, 1'b0}
                    + 68'(digit_scale(i_tok.digit, 4'(FRAC_EFF)));
    assign int_mant = (int_sum > 68'(MAG_CAP)) ? MAG_CAP : int_sum[63:0];

    assign frac_room = (r_fc < 4'(FRAC_EFF));
    assign frac_exp  = 4'(FRAC_EFF) - 4'd1 - r_fc;
    assign frac_sum  = {1'b0, r_mant} + 65'(digit_scale(i_tok.digit, frac_exp));
    assign frac_mant = (frac_sum > 65'(MAG_CAP)) ? MAG_CAP : frac_sum[63:0];

    always_comb begin
        int_rule = 1'b0;
        case (r_phase)
            PH_BLANK: int_rule = !(i_tok.cls == CLS_BLANK || i_tok.cls == CLS_MINUS
                                   || i_tok.cls == CLS_PLUS);
            PH_MINUS: int_rule = (i_tok.cls != CLS_PLUS);
            PH_INT:   int_rule = 1'b1;
            default:  int_rule = 1'b0;
        endcase
    end

    always_comb begin
        n_cc    = r_cc;
        n_has   = r_has;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_mant  = r_mant;
        n_fc    = r_fc;
        for (int k = 0; k < 4; k++) begin
            n_fld[k] = r_fld[k];
        end
        o_res_push = 1'b0;

        if (take) begin
            if (i_tok.cls == CLS_EOL) begin
                o_res_push = r_has && (r_cc >= FIELD_COUNT_MIN);
                n_cc    = '0;
                n_has   = 1'b0;
                n_phase = PH_BLANK;
                n_neg   = 1'b0;
                n_mant  = '0;
                n_fc    = '0;
                for (int k = 0; k < 4; k++) begin
                    n_fld[k] = '0;
                end
            end else begin
                n_has = 1'b1;
                if (i_tok.cls == CLS_COMMA) begin
                    if (r_cc < FIELD_COUNT_MIN) begin
                        if (r_cc >= FIELD_FIRST) begin
                            n_fld[2'(r_cc - FIELD_FIRST)] = num_val;
                        end
                        n_cc    = r_cc + 3'd1;
                        n_phase = PH_BLANK;
                        n_neg   = 1'b0;
                        n_mant  = '0;
                        n_fc    = '0;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end else if (r_phase == PH_BLANK && i_tok.cls == CLS_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = PH_MINUS;
                end else if ((r_phase == PH_BLANK || r_phase == PH_MINUS)
                             && i_tok.cls == CLS_PLUS) begin
                    n_phase = PH_INT;
                end else if (r_phase == PH_BLANK && i_tok.cls == CLS_BLANK) begin
                    n_phase = PH_BLANK;
                end else if (int_rule) begin
                    if (i_tok.cls == CLS_DIGIT) begin
                        n_mant  = int_mant;
                        n_phase = PH_INT;
                    end else if (i_tok.cls == CLS_POINT) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end else if (r_phase == PH_FRAC && i_tok.cls == CLS_DIGIT) begin
                    if (frac_room) begin
                        n_mant = frac_mant;
                        n_fc   = r_fc + 4'd1;
                    end
                end else begin
                    n_phase = PH_STOP;
                end
            end
        end
    end

    always_comb begin
        o_res.open_value   = r_fld[0];
        o_res.high_value   = r_fld[1];
        o_res.low_value    = r_fld[2];
        o_res.close_value  = r_fld[3];
        o_res.volume_value = num_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc    <= '0;
            r_has   <= 1'b0;
            r_phase <= PH_BLANK;
            r_neg   <= 1'b0;
            r_mant  <= '0;
            r_fc    <= '0;
            for (int k = 0; k < 4; k++) begin
                r_fld[k] <= '0;
            end
        end else begin
            r_cc    <= n_cc;
            r_has   <= n_has;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mant  <= n_mant;
            r_fc    <= n_fc;
            for (int k = 0; k < 4; k++) begin
                r_fld[k] <= n_fld[k];
            end
        end
    end

endmodule

// File: rtl/cprp_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprp_res_fifo
// Output queue holding finished row results until they are popped.
// ----------------------------------------------------------------------------
module cprp_res_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cprp_pkg::t_res i_res,
    output logic           o_full,
    output logic           empty,
    output cprp_pkg::t_res o_res,
    input  logic           pop
);
    import cprp_pkg::*;

    t_res              r_mem [RES_DEPTH];
    logic [RES_AW-1:0] r_wr;
    logic [RES_AW-1:0] r_rd;
    logic [RES_AW:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == (RES_AW+1)'(RES_DEPTH));
    assign empty   = (r_cnt == '0);
    assign o_res   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/csv_price_row_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_price_row_parser_top
// Streaming parser for comma-separated price rows.
// ----------------------------------------------------------------------------
// Push one byte of file text per cycle; the first line of each file is
// skipped as header. A row with at least seven fields yields one result with
// fields three to seven as signed fixed point scaled by 10^FRAC_DIGITS, popped
// from the output queue. The parser takes one byte per clock unless full is
// high: full is held while the row is closed for a file whose last byte comes
// after the header line and is not itself a line end, and whenever the token
// queue is full. Results wait in a two-entry queue, and the two-entry token
// queue behind the classifier fills only once that result queue has filled.
// ----------------------------------------------------------------------------
module csv_price_row_parser_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  cprp_pkg::t_in  i_in,
    output logic           empty,
    input  logic           pop,
    output cprp_pkg::t_res o_res
);
    import cprp_pkg::*;

    logic tok_push;
    t_tok tok_in;
    logic tok_full;
    logic tok_valid;
    t_tok tok_out;
    logic tok_pop;
    logic res_push;
    t_res res_in;
    logic res_full;

    cprp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .o_tok_push (tok_push),
        .o_tok      (tok_in),
        .i_tok_full (tok_full)
    );

    cprp_tok_fifo u_tok_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_tok   (tok_in),
        .o_full  (tok_full),
        .o_valid (tok_valid),
        .o_tok   (tok_out),
        .i_pop   (tok_pop)
    );

    cprp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok_out),
        .o_tok_pop   (tok_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    cprp_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .empty   (empty),
        .o_res   (o_res),
        .pop     (pop)
    );

endmodule

// File: test/csv_price_row_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csv_price_row_parser_top_tb
// Self-checking bench for the streaming price row parser.
// ----------------------------------------------------------------------------
// Pushes file text one byte per transaction and pops parsed rows. A short table
// of hand-written lines covers headers, line ends, end of file, malformed numbers,
// truncation and saturation. Random files follow, mostly well-formed rows with
// random numbers, mixed with empty lines, noise bytes, odd field counts and
// cut-off files. Every popped row is compared field by field with the table on
// typed lines, else with a bit-exact parser model in the bench. Both sides idle
// at random, and once the output side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module csv_price_row_parser_top_tb;

    import cprp_pkg::*;

    localparam int          HOLD_CYCLES    = 1500;
    localparam int          WATCHDOG_LIMIT = 6000;
    localparam int          RANDOM_BYTES   = 850;
    localparam longint      SAT_HI         = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint      SAT_LO         = 64'h8000_0000_0000_0000;

    typedef struct {
        string text;
        bit    eof;
        bit    typed;
        t_res  want;
    } t_text_case;

    logic i_clk;
    logic i_rst_n;
    logic push;
    logic full;
    t_in  i_in;
    logic empty;
    logic pop;
    t_res o_res;

    csv_price_row_parser_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_in    (i_in),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    // parser model state
    logic        hdr_skip;
    logic [2:0]  n_commas;
    logic        row_started;
    t_phase      num_ph;
    logic        num_neg;
    logic [63:0] num_mag;
    logic [3:0]  frac_n;
    logic [63:0] done_vals [4];

    t_res        pending_rows [$];
    logic [7:0]  text_q [$];
    t_text_case  dir_cases [16];
    string       field_names [5] = '{"open", "high", "low", "close", "volume"};
    bit          calm;
    int          n_errors;
    int unsigned rows_popped;
    int unsigned idle_cycles;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [63:0] ten_to(input int n);
        logic [63:0] p;
        p = 64'd1;
        repeat (n) p = p * 64'd10;
        return p;
    endfunction

    function automatic void clear_number();
        num_ph  = PH_BLANK;
        num_neg = 1'b0;
        num_mag = '0;
        frac_n  = '0;
    endfunction

    function automatic void clear_line();
        n_commas    = '0;
        row_started = 1'b0;
        clear_number();
        foreach (done_vals[k]) done_vals[k] = '0;
    endfunction

    function automatic void restart_file();
        hdr_skip = 1'b1;
        clear_line();
    endfunction

    function automatic logic [63:0] field_value();
        if (num_neg) return 64'd0 - num_mag;
        return (num_mag >= MAG_CAP) ? MAG_MAX : num_mag;
    endfunction

    function automatic bit close_line(output t_res row);
        bit got;
        got = row_started && (n_commas >= 3'd6);
        row = '{open_value: done_vals[0], high_value: done_vals[1],
                low_value: done_vals[2], close_value: done_vals[3],
                volume_value: field_value()};
        clear_line();
        return got;
    endfunction

    function automatic bit parse_byte(input logic [7:0] c, input logic e, output t_res row);
        bit          got;
        bit          is_digit;
        logic [63:0] add;
        got      = 1'b0;
        row      = '0;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (hdr_skip) begin
            if (c == CH_LF) hdr_skip = 1'b0;
        end else if (c == CH_LF || c == CH_CR) begin
            got = close_line(row);
        end else begin
            row_started = 1'b1;
            if (c == CH_COMMA) begin
                if (n_commas < 3'd6) begin
                    if (n_commas >= 3'd2) done_vals[2'(n_commas - 3'd2)] = field_value();
                    n_commas = n_commas + 3'd1;
                    clear_number();
                end else begin
                    num_ph = PH_STOP;
                end
            end else begin
                case (num_ph)
                    PH_BLANK, PH_MINUS, PH_INT: begin
                        if (num_ph == PH_BLANK && (c == CH_SPACE || c == CH_TAB)) begin
                        end else if (num_ph == PH_BLANK && c == CH_MINUS) begin
                            num_neg = 1'b1;
                            num_ph  = PH_MINUS;
                        end else if (num_ph != PH_INT && c == CH_PLUS) begin
                            num_ph = PH_INT;
                        end else if (is_digit) begin
                            add = 64'(c[3:0]) * ten_to(FRAC_EFF);
                            if (num_mag > (MAG_CAP - add) / 64'd10) num_mag = MAG_CAP;
                            else num_mag = num_mag * 64'd10 + add;
                            num_ph = PH_INT;
                        end else if (c == CH_POINT) begin
                            num_ph = PH_FRAC;
                        end else begin
                            num_ph = PH_STOP;
                        end
                    end
                    PH_FRAC: begin
                        if (is_digit) begin
                            if (frac_n < FRAC_EFF) begin
                                add = 64'(c[3:0]) * ten_to(FRAC_EFF - 1 - int'(frac_n));
                                frac_n = frac_n + 4'd1;
                                num_mag = (MAG_CAP - num_mag < add) ? MAG_CAP : num_mag + add;
                            end
                        end else begin
                            num_ph = PH_STOP;
                        end
                    end
                    default: num_ph = PH_STOP;
                endcase
            end
        end
        if (e) begin
            if (!got && !hdr_skip) got = close_line(row);
            restart_file();
        end
        return got;
    endfunction

    function automatic t_text_case line_case(input string text, input bit eof, input bit typed,
                                             input longint o = 0, input longint h = 0,
                                             input longint l = 0, input longint c = 0,
                                             input longint v = 0);
        t_text_case tc;
        tc.text  = text;
        tc.eof   = eof;
        tc.typed = typed;
        tc.want  = '{open_value: o, high_value: h, low_value: l, close_value: c,
                     volume_value: v};
        return tc;
    endfunction

    function automatic void add_text(input logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_byte(input logic [7:0] b, input logic e, input bit typed,
                             input t_res want);
        int unsigned gap;
        t_res        row;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push = 1'b1;
        i_in = '{data_byte: b, end_of_file: e};
        do @(posedge i_clk); while (full);
        if (parse_byte(b, e, row)) begin
            if (typed) row = want;
            pending_rows = {pending_rows, row};
        end
        @(negedge i_clk);
    endtask

    task automatic build_file();
        int unsigned kind;
        int unsigned n_fields;
        int unsigned n;
        logic [7:0]  ch;
        text_q.delete();
        repeat ($urandom_range(1, 16)) add_text(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 9) != 0) begin
            add_text(CH_LF);
            for (int r = 0; r < $urandom_range(0, 8); r++) begin
                kind = $urandom_range(0, 15);
                if (kind == 0) begin
                    add_text(CH_LF);
                end else if (kind == 1) begin
                    add_text(CH_CR);
                    add_text(CH_LF);
                end else if (kind == 2) begin
                    repeat ($urandom_range(1, 24)) add_text(8'($urandom_range(0, 255)));
                    add_text(CH_LF);
                end else begin
                    n_fields = (kind == 3) ? $urandom_range(1, 10) : 7;
                    for (int f = 0; f < n_fields; f++) begin
                        if (f != 0) add_text(CH_COMMA);
                        if (f < 2) begin
                            repeat ($urandom_range(0, 6)) begin
                                ch = 8'($urandom_range(33, 126));
                                add_text((ch == CH_COMMA) ? CH_PLUS : ch);
                            end
                        end else begin
                            if ($urandom_range(0, 3) == 0) begin
                                repeat ($urandom_range(1, 2))
                                    add_text($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                            end
                            if ($urandom_range(0, 3) == 0) add_text(CH_MINUS);
                            if ($urandom_range(0, 7) == 0) add_text(CH_PLUS);
                            n = $urandom_range(0, 15);
                            n = (n == 0) ? 0 : (n == 15) ? $urandom_range(13, 22)
                                                         : $urandom_range(1, 6);
                            repeat (n) add_text(CH_ZERO + 8'($urandom_range(0, 9)));
                            if ($urandom_range(0, 2) == 0) begin
                                add_text(CH_POINT);
                                repeat ($urandom_range(0, 9))
                                    add_text(CH_ZERO + 8'($urandom_range(0, 9)));
                            end
                            if ($urandom_range(0, 9) == 0)
                                add_text(8'($urandom_range(0, 255)));
                        end
                    end
                    case ($urandom_range(0, 3))
                        0, 1: add_text(CH_LF);
                        2: begin
                            add_text(CH_CR);
                            add_text(CH_LF);
                        end
                        default: add_text(CH_CR);
                    endcase
                end
            end
            kind = $urandom_range(0, 5);
            if (kind == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    if (text_q.size() > 1) void'(text_q.pop_back());
                end
            end else if (kind == 1) begin
                while (text_q.size() > 1 && (text_q[$] == CH_LF || text_q[$] == CH_CR))
                    void'(text_q.pop_back());
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : row_side
        int unsigned wait_n;
        bit          held;
        t_res        want;
        logic [319:0] exp_bits;
        logic [319:0] got_bits;
        pop  = 1'b0;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held && rows_popped >= 12) begin
                held = 1'b1;
                pop  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            wait_n = calm ? 0 : $urandom_range(0, 6);
            if (wait_n != 0) begin
                pop = 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
            rows_popped++;
            if (pending_rows.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected row, expected none, got %h", $time, o_res);
            end else begin
                want     = pending_rows.pop_front();
                exp_bits = want;
                got_bits = o_res;
                for (int k = 0; k < 5; k++) begin
                    if (exp_bits[319 - 64 * k -: 64] !== got_bits[319 - 64 * k -: 64]) begin
                        n_errors++;
                        $display("%0t: %s mismatch, expected %0d, got %0d", $time,
                                 field_names[k], $signed(exp_bits[319 - 64 * k -: 64]),
                                 $signed(got_bits[319 - 64 * k -: 64]));
                    end
                end
            end
        end
    end

    initial begin : byte_side
        int unsigned sent;
        string       s;
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_in           = '0;
        calm           = 1'b0;
        n_errors       = 0;
        rows_popped    = 0;
        restart_file();
        dir_cases = '{
            line_case("Date,Sym,Open,High,Low,Close,Volume\n", 1'b0, 1'b0),
            line_case("d,s,1,2,3,4,5\n", 1'b0, 1'b1,
                      1000000, 2000000, 3000000, 4000000, 5000000),
            line_case("d,s,-1.5,+2.25, 3,\t4.0000009,0\n", 1'b0, 1'b1,
                      -1500000, 2250000, 3000000, 4000000, 0),
            line_case({"x,y,99999999999999999999,-99999999999999999999,",
                       "-9223372036854.775808,9223372036854.775808,-\n"}, 1'b0, 1'b1,
                      SAT_HI, SAT_LO, SAT_LO, SAT_HI, 0),
            line_case("\r\n", 1'b0, 1'b0),
            line_case("d,s,1,2,3\n", 1'b0, 1'b0),
            line_case("d,s,1,2,3,4,5,6,7\r", 1'b0, 1'b1,
                      1000000, 2000000, 3000000, 4000000, 5000000),
            line_case("d,s,abc,1x2,-+3,.5,7.\n", 1'b0, 1'b1,
                      0, 1000000, -3000000, 500000, 7000000),
            line_case("d,s,+-1,--1,1.2.3, 0.000001,12 3\n", 1'b0, 1'b1,
                      0, 0, 1200000, 1, 12000000),
            line_case(",,,,,,\n", 1'b0, 1'b1, 0, 0, 0, 0, 0),
            line_case("d,s,1,2,3,4,5", 1'b1, 1'b1,
                      1000000, 2000000, 3000000, 4000000, 5000000),
            line_case("hdr\n", 1'b0, 1'b0),
            line_case("d,s,9,8,7,6,5\n", 1'b1, 1'b1,
                      9000000, 8000000, 7000000, 6000000, 5000000),
            line_case("no,line,feed,1,2,3,4", 1'b1, 1'b0),
            line_case("h\n", 1'b0, 1'b0),
            line_case("a,b,-0,0.0,+0,-.9999999,-1", 1'b1, 1'b1,
                      0, 0, 0, -999999, -1000000)
        };
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_cases[r]) begin
            s = dir_cases[r].text;
            for (int i = 0; i < s.len(); i++)
                send_byte(s[i], dir_cases[r].eof && (i == s.len() - 1),
                          dir_cases[r].typed, dir_cases[r].want);
        end

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 4) == 0);
            build_file();
            for (int i = 0; i < text_q.size(); i++)
                send_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
            sent += text_q.size();
        end
        calm = 1'b0;
        push = 1'b0;

        while (pending_rows.size() != 0) @(negedge i_clk);
        repeat (64) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
